[rtl/core/spqr_pkg.sv]
// ----------------------------------------------------------------------------
// spqr_pkg
// Types and codes shared by the sorted ready queue and its slot cells.
// ----------------------------------------------------------------------------
package spqr_pkg;

    localparam int ID_W       = 4;
    localparam int PRIO_W     = 8;
    localparam int OCC_W      = 5;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   proc_id;
        logic [PRIO_W-1:0] entry_priority;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
    } out_item_t;

    // per-cycle command broadcast to every slot cell
    typedef struct packed {
        logic enq;   // insert accepted and queue not full
        logic deq;   // remove accepted and queue not empty
    } cell_ctrl_t;

endpackage

[rtl/core/spqr_cell.sv]
// ----------------------------------------------------------------------------
// spqr_cell
// One slot of the sorted queue: holds an id and a priority, shifts toward the
// tail on an insert ahead of it and toward the head on removal.
// ----------------------------------------------------------------------------
module spqr_cell #(
    parameter int PW = 8
) (
    input  logic                      aclk,
    input  spqr_pkg::cell_ctrl_t      ctrl,
    input  logic [spqr_pkg::ID_W-1:0] new_id,
    input  logic [PW-1:0]             new_prio,
    input  logic                      occupied,
    input  logic                      at_tail,
    input  logic                      left_shift,
    input  logic [spqr_pkg::ID_W-1:0] left_id,
    input  logic [PW-1:0]             left_prio,
    input  logic [spqr_pkg::ID_W-1:0] right_id,
    input  logic [PW-1:0]             right_prio,
    output logic                      shift,
    output logic [spqr_pkg::ID_W-1:0] id,
    output logic [PW-1:0]             prio
);

    logic [spqr_pkg::ID_W-1:0] id_reg,   id_next;
    logic [PW-1:0]             prio_reg, prio_next;

    // held entry is strictly lower than the newcomer: it moves one slot down
    assign shift = occupied && (prio_reg < new_prio);

    always_comb begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.enq) begin
            if (left_shift) begin
                id_next   = left_id;
                prio_next = left_prio;
            end else if (shift || at_tail) begin
                id_next   = new_id;
                prio_next = new_prio;
            end
        end else if (ctrl.deq) begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id   = id_reg;
    assign prio = prio_reg;

endmodule

[rtl/core/stable_priority_ready_queue_unit.sv]
// Result: registered on the input transfer and valid in the output register in the next cycle.
// Throughput: 1 item per cycle while the output register is empty or being taken; every slot
// cell compares against the new priority in parallel and shifts one place in the same cycle.
// Reset: aresetn (synchronous, low) empties the queue and clears the output
// valid; slot contents are not reset and are only read below the fill count.
// ----------------------------------------------------------------------------
// stable_priority_ready_queue_unit
// Bounded ready queue of process ids in descending priority order, built as
// a row of slot cells; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spqr_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output spqr_pkg::out_item_t m_result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (PRIORITY_BITS < spqr_pkg::PRIO_W) ? PRIORITY_BITS
                                                           : spqr_pkg::PRIO_W;

    logic [CW-1:0]             count_reg, count_next;
    logic                      m_valid_reg;
    spqr_pkg::out_item_t       result_reg, result_next;

    logic                      in_xfer;
    logic                      is_deq, empty, full;
    spqr_pkg::cell_ctrl_t      ctrl;
    logic [SW-1:0]             new_prio;
    logic [CW+spqr_pkg::OCC_W-1:0] occ_wide;

    logic [spqr_pkg::ID_W-1:0] cell_id    [QUEUE_DEPTH];
    logic [SW-1:0]             cell_prio  [QUEUE_DEPTH];
    logic                      cell_shift [QUEUE_DEPTH];

    assign s_ready  = !m_valid_reg || m_ready;
    assign in_xfer  = s_valid && s_ready;
    assign is_deq   = (s_item.mode == spqr_pkg::MODE_DEQ);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign new_prio = s_item.entry_priority[SW-1:0];

    assign ctrl.enq = in_xfer && !is_deq && !full;
    assign ctrl.deq = in_xfer && is_deq && !empty;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                      l_shift;
            logic [spqr_pkg::ID_W-1:0] l_id,  r_id;
            logic [SW-1:0]             l_prio, r_prio;

            if (g == 0) begin : g_head
                assign l_shift = 1'b0;
                assign l_id    = s_item.proc_id;
                assign l_prio  = new_prio;
            end else begin : g_body
                assign l_shift = cell_shift[g-1];
                assign l_id    = cell_id[g-1];
                assign l_prio  = cell_prio[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign r_id   = cell_id[g];
                assign r_prio = cell_prio[g];
            end else begin : g_inner
                assign r_id   = cell_id[g+1];
                assign r_prio = cell_prio[g+1];
            end

            spqr_cell #(
                .PW (SW)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .new_id     (s_item.proc_id),
                .new_prio   (new_prio),
                .occupied   (CW'(g) < count_reg),
                .at_tail    (CW'(g) == count_reg),
                .left_shift (l_shift),
                .left_id    (l_id),
                .left_prio  (l_prio),
                .right_id   (r_id),
                .right_prio (r_prio),
                .shift      (cell_shift[g]),
                .id         (cell_id[g]),
                .prio       (cell_prio[g])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctrl.enq) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.deq) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign occ_wide = (CW+spqr_pkg::OCC_W)'(count_next);

    always_comb begin
        result_next              = result_reg;
        result_next.out_id       = '0;
        result_next.out_priority = '0;
        result_next.status       = spqr_pkg::STATUS_OK;
        result_next.occupancy    = occ_wide[spqr_pkg::OCC_W-1:0];
        if (is_deq) begin
            if (empty) begin
                result_next.status = spqr_pkg::STATUS_EMPTY;
            end else begin
                result_next.out_id       = cell_id[0];
                result_next.out_priority = spqr_pkg::PRIO_W'(cell_prio[0]);
            end
        end else if (full) begin
            result_next.status = spqr_pkg::STATUS_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    // fill count stays within the row of cells
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a successful removal drops the count by one
    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.deq |=> count_reg == $past(count_reg) - 1'b1)
        else $error("count not decremented on removal");

    // the head never ranks below the next entry
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(2)) |-> cell_prio[0] >= cell_prio[1])
        else $error("head out of priority order");

    // a transfer that meets an empty or full queue leaves the count alone
    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !ctrl.enq && !ctrl.deq) |=> $stable(count_reg))
        else $error("rejected item changed the count");

endmodule

[bench/stable_priority_ready_queue_checker.sv]
// ----------------------------------------------------------------------------
// stable_priority_ready_queue_checker
// Watches both channels of the sorted ready queue. It keeps its own copy of
// the queue, works out the result of every accepted request and compares each
// accepted result, field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue_checker #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  spqr_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  spqr_pkg::out_item_t m_result,
    output int                  fail_count,
    output int                  outstanding
);

    localparam logic [spqr_pkg::PRIO_W-1:0] PRIO_KEEP =
        spqr_pkg::PRIO_W'((64'd1 << PRIORITY_BITS) - 64'd1);

    logic [spqr_pkg::ID_W-1:0]   slot_id   [QUEUE_DEPTH];
    logic [spqr_pkg::PRIO_W-1:0] slot_prio [QUEUE_DEPTH];
    int                          held = 0;
    spqr_pkg::out_item_t         results_due[$];

    task automatic report_mismatch(input string msg);
        $display("%0t: ERROR %s", $time, msg);
        fail_count++;
    endtask

    // Applies one request to the local queue and returns the result it causes.
    task automatic schedule_item(input spqr_pkg::in_item_t req,
                                 output spqr_pkg::out_item_t res);
        logic [spqr_pkg::PRIO_W-1:0] prio;
        int                          pos;
        int                          i;
        res        = '0;
        res.status = spqr_pkg::STATUS_OK;
        prio       = req.entry_priority & PRIO_KEEP;
        if (req.mode == spqr_pkg::MODE_DEQ) begin
            if (held == 0) begin
                res.status = spqr_pkg::STATUS_EMPTY;
            end else begin
                res.out_id       = slot_id[0];
                res.out_priority = slot_prio[0];
                for (i = 1; i < held; i++) begin
                    slot_id[i-1]   = slot_id[i];
                    slot_prio[i-1] = slot_prio[i];
                end
                held--;
            end
        end else if (held >= QUEUE_DEPTH) begin
            res.status = spqr_pkg::STATUS_FULL;
        end else begin
            // new entry goes behind everything of greater or equal priority
            pos = held;
            for (i = 0; i < held; i++) begin
                if (slot_prio[i] < prio) begin
                    pos = i;
                    break;
                end
            end
            for (i = held; i > pos; i--) begin
                slot_id[i]   = slot_id[i-1];
                slot_prio[i] = slot_prio[i-1];
            end
            slot_id[pos]   = req.proc_id;
            slot_prio[pos] = prio;
            held++;
        end
        res.occupancy = spqr_pkg::OCC_W'(held);
    endtask

    always @(posedge aclk) begin
        spqr_pkg::out_item_t due;
        if (!aresetn) begin
            held = 0;
            results_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                schedule_item(s_item, due);
                results_due.push_back(due);
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result transfer with none due: %p", m_result));
                end else begin
                    due = results_due.pop_front();
                    if (m_result.out_id !== due.out_id)
                        report_mismatch($sformatf("out_id got %0d, expected %0d",
                                                  m_result.out_id, due.out_id));
                    if (m_result.out_priority !== due.out_priority)
                        report_mismatch($sformatf("out_priority got %0d, expected %0d",
                                                  m_result.out_priority, due.out_priority));
                    if (m_result.status !== due.status)
                        report_mismatch($sformatf("status got %0d, expected %0d",
                                                  m_result.status, due.status));
                    if (m_result.occupancy !== due.occupancy)
                        report_mismatch($sformatf("occupancy got %0d, expected %0d",
                                                  m_result.occupancy, due.occupancy));
                end
            end
        end
        outstanding <= results_due.size();
    end

endmodule

[bench/stable_priority_ready_queue_unit_tb.sv]
// ----------------------------------------------------------------------------
// stable_priority_ready_queue_unit_tb
// Drives enqueue and dequeue requests into the sorted ready queue: a directed
// pass over empty, full, extreme and equal-priority cases, then random
// segments that push the queue toward full or empty, with random idle cycles
// on both channels. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue_unit_tb;

    localparam int DEPTH        = 16;
    localparam int SEGMENTS     = 30;
    localparam int SEGMENT_LEN  = 40;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    spqr_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    spqr_pkg::out_item_t m_result;
    int                  fail_count;
    int                  outstanding;

    bit                  src_burst  = 1'b0;
    bit                  sink_burst = 1'b0;

    stable_priority_ready_queue_unit #(
        .QUEUE_DEPTH   (DEPTH),
        .PRIORITY_BITS (spqr_pkg::PRIO_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    stable_priority_ready_queue_checker #(
        .QUEUE_DEPTH   (DEPTH),
        .PRIORITY_BITS (spqr_pkg::PRIO_W)
    ) queue_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One request transfer, preceded by a random idle gap.
    task automatic send_request(input logic mode,
                                input logic [spqr_pkg::ID_W-1:0] id,
                                input logic [spqr_pkg::PRIO_W-1:0] prio);
        spqr_pkg::in_item_t req;
        int                 gap;
        req.mode           = mode;
        req.proc_id        = id;
        req.entry_priority = prio;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds off the sender until every result due has been taken.
    task automatic drain_results();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // result side: random stall after each transfer
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [spqr_pkg::PRIO_W-1:0] fill_prio [10];
        int                          enq_pct;
        logic                        mode;
        logic [spqr_pkg::PRIO_W-1:0] prio;
        fill_prio = '{8'd128, 8'd64, 8'd255, 8'd1, 8'd254,
                      8'd127, 8'd128, 8'd0, 8'd200, 8'd64};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue, ignored fields set high
        send_request(spqr_pkg::MODE_DEQ, 4'd15, 8'd255);
        // extremes and ties, then fill to the top
        send_request(spqr_pkg::MODE_ENQ, 4'd0, 8'd0);
        send_request(spqr_pkg::MODE_ENQ, 4'd15, 8'd255);
        send_request(spqr_pkg::MODE_ENQ, 4'd1, 8'd128);
        send_request(spqr_pkg::MODE_ENQ, 4'd2, 8'd128);
        send_request(spqr_pkg::MODE_ENQ, 4'd3, 8'd0);
        send_request(spqr_pkg::MODE_ENQ, 4'd4, 8'd255);
        for (int i = 0; i < 10; i++)
            send_request(spqr_pkg::MODE_ENQ, spqr_pkg::ID_W'(i + 5), fill_prio[i]);
        // full queue drops both a top and a bottom priority entry
        send_request(spqr_pkg::MODE_ENQ, 4'd15, 8'd255);
        send_request(spqr_pkg::MODE_ENQ, 4'd0, 8'd0);
        repeat (3) send_request(spqr_pkg::MODE_DEQ, 4'd0, 8'd0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(0, 2))
                0: enq_pct = 15;
                1: enq_pct = 50;
                default: enq_pct = 85;
            endcase
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            if (seg == SEGMENTS / 2) begin
                s_valid <= 1'b0;
                drain_results();
            end
            for (int k = 0; k < SEGMENT_LEN; k++) begin
                mode = ($urandom_range(0, 99) < enq_pct) ? spqr_pkg::MODE_ENQ
                                                         : spqr_pkg::MODE_DEQ;
                // narrow priority sets make ties common
                case ($urandom_range(0, 3))
                    0: prio = spqr_pkg::PRIO_W'($urandom_range(0, 3));
                    1: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default: prio = spqr_pkg::PRIO_W'($urandom_range(0, 255));
                endcase
                send_request(mode, spqr_pkg::ID_W'($urandom_range(0, 15)), prio);
            end
        end
        s_valid <= 1'b0;
        src_burst  = 1'b0;
        sink_burst = 1'b0;

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
